// File: design/djs_pkg.sv
// ---------------------------------------------------------------------------
// djs_pkg: shared types for the dependency-aware job scheduler
// Item and result structs, function and status codes.
// ---------------------------------------------------------------------------
`default_nettype none

package djs_pkg;

  typedef enum logic [2:0] {
    FUNC_OPEN   = 3'd0,
    FUNC_ADD    = 3'd1,
    FUNC_COMMIT = 3'd2,
    FUNC_FETCH  = 3'd3,
    FUNC_DONE   = 3'd4,
    FUNC_QUERY  = 3'd5
  } func_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_NO_JOB  = 3'd2,
    ST_NO_OPEN = 3'd3,
    ST_DEP_FULL = 3'd4
  } status_e;

  typedef struct packed {
    logic [2:0]  func;
    logic [15:0] job_count;
    logic [31:0] label;
  } item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] out_label;
    logic [15:0] work_index;
    logic        finished;
    logic        wake_one;
    logic        wake_all;
    logic        wake_waiters;
  } result_t;

endpackage

`default_nettype wire

// File: design/djs_ram.sv
// ---------------------------------------------------------------------------
// djs_ram: generic single-port-write, single-read RAM
// One write and one registered read per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module djs_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: design/dependency_aware_job_scheduler_unit.sv
// ---------------------------------------------------------------------------
// dependency_aware_job_scheduler_unit: job scheduler with dependency counters
// Ring of job contexts in one RAM, dependant labels in a second RAM.
//
//   channel   handshake            payload
//   item in   start_i / busy_o     item_i   (djs_pkg::item_t)
//   result    result_valid_o       result_o (djs_pkg::result_t)
//   config    cfg_valid_i/ready_o  cfg_data_i (start_on_dispatch)
//
// Each item reads its context, then executes; busy stays high until the result.
// Add also bumps the open job's blockers; complete, when the job frees, walks
// its dependants. Fetch visits contexts until one is runnable or none is left.
// After reset a clearing pass writes every context, busy high.
// Results show for one cycle; the receiver cannot stall.
// ---------------------------------------------------------------------------
`default_nettype none

module dependency_aware_job_scheduler_unit #(
  parameter int CONTEXTS       = 256,
  parameter int MAX_DEPENDANTS = 8,
  parameter int LABEL_BITS     = 32,
  parameter int COUNT_BITS     = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  output logic                   busy_o,
  input  wire djs_pkg::item_t    item_i,
  output logic                   result_valid_o,
  output djs_pkg::result_t       result_o,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic              cfg_data_i
);

  localparam int SB = $clog2(CONTEXTS);
  localparam int WCB = $clog2(MAX_DEPENDANTS + 1);
  localparam int BB = $clog2(CONTEXTS * MAX_DEPENDANTS + 1);
  localparam int FB = $clog2(CONTEXTS + 1);
  localparam int WAB = $clog2(CONTEXTS * MAX_DEPENDANTS);
  localparam int NB = COUNT_BITS + 1;
  localparam int CW = LABEL_BITS + NB + 2 * COUNT_BITS + BB + WCB;

  typedef struct packed {
    logic [LABEL_BITS-1:0] owner;
    logic [NB-1:0]         next_item;
    logic [COUNT_BITS-1:0] left;
    logic [COUNT_BITS-1:0] total;
    logic [BB-1:0]         blockers;
    logic [WCB-1:0]        wcnt;
  } ctx_t;

  typedef enum logic [10:0] {
    S_CLEAR = 11'b00000000001,
    S_IDLE  = 11'b00000000010,
    S_RD    = 11'b00000000100,
    S_EXEC  = 11'b00000001000,
    S_RD2   = 11'b00000010000,
    S_EXEC2 = 11'b00000100000,
    S_FRD   = 11'b00001000000,
    S_FEX   = 11'b00010000000,
    S_WRD   = 11'b00100000000,
    S_WLAB  = 11'b01000000000,
    S_WEX   = 11'b10000000000
  } state_e;

  state_e state_q, state_d;
  logic sod_q;
  logic [LABEL_BITS-1:0] start_q, start_d, end_q, end_d, lc_q, lc_d;
  logic [FB-1:0] inf_q, inf_d;
  logic open_q, open_d;
  logic [SB-1:0] oslot_q, oslot_d;
  logic [SB:0] clr_q, clr_d;
  djs_pkg::item_t it_q, it_d;
  djs_pkg::result_t res_q, res_d;
  logic rv_q, rv_d;
  logic [FB-1:0] fi_q, fi_d, fd_q, fd_d;
  logic head_q, head_d;
  logic [LABEL_BITS-1:0] fl_q, fl_d;
  logic [WCB-1:0] wk_q, wk_d, wn_q, wn_d;
  logic [SB-1:0] fs_q, fs_d;
  logic [LABEL_BITS-1:0] wl_q, wl_d;

  logic c_we;
  logic [SB-1:0] c_wa, c_ra;
  ctx_t c_wd, c_rd;
  logic w_we;
  logic [WAB-1:0] w_wa, w_ra;
  logic [LABEL_BITS-1:0] w_wd, w_rd;

  djs_ram #(.Width(CW), .Depth(CONTEXTS)) u_ctx (
    .clk_i, .we_i(c_we), .waddr_i(c_wa), .wdata_i(c_wd), .raddr_i(c_ra),
    .rdata_o(c_rd)
  );
  djs_ram #(.Width(LABEL_BITS), .Depth(CONTEXTS * MAX_DEPENDANTS)) u_wait (
    .clk_i, .we_i(w_we), .waddr_i(w_wa), .wdata_i(w_wd), .raddr_i(w_ra),
    .rdata_o(w_rd)
  );

  logic [LABEL_BITS-1:0] nl, dd;
  logic live;

  always_comb begin
    logic [LABEL_BITS-1:0] il;
    logic [COUNT_BITS-1:0] cnt;
    state_d = state_q; start_d = start_q; end_d = end_q; lc_d = lc_q;
    inf_d = inf_q; open_d = open_q; oslot_d = oslot_q; clr_d = clr_q;
    it_d = it_q; res_d = res_q; rv_d = 1'b0;
    fi_d = fi_q; fd_d = fd_q; head_d = head_q; fl_d = fl_q;
    wk_d = wk_q; wn_d = wn_q; fs_d = fs_q; wl_d = wl_q;
    c_we = 1'b0; c_wa = '0; c_wd = c_rd; c_ra = '0;
    w_we = 1'b0; w_wa = '0; w_wd = '0; w_ra = '0;
    il = LABEL_BITS'(it_q.label);
    cnt = COUNT_BITS'(it_q.job_count);
    nl = lc_q + 1'b1;
    dd = end_q - start_q;
    live = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        c_we = 1'b1; c_wa = clr_q[SB-1:0]; c_wd = '0;
        clr_d = clr_q + 1'b1;
        if (clr_q == (SB+1)'(CONTEXTS - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start_i) begin
          it_d = item_i; state_d = S_RD;
        end
      end
      S_RD: begin
        res_d = '0;
        if (it_q.func == djs_pkg::FUNC_OPEN) c_ra = nl[SB-1:0];
        else if (it_q.func == djs_pkg::FUNC_COMMIT) c_ra = oslot_q;
        else c_ra = il[SB-1:0];
        if (it_q.func == djs_pkg::FUNC_FETCH) begin
          if (dd > LABEL_BITS'(CONTEXTS)) begin
            start_d = end_q - LABEL_BITS'(CONTEXTS);
            fd_d = FB'(CONTEXTS);
          end else begin
            fd_d = FB'(dd);
          end
          fi_d = '0; head_d = 1'b1;
          state_d = S_FRD;
        end else begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        live = c_rd.owner == il && c_rd.left != '0;
        state_d = S_IDLE; rv_d = 1'b1;
        case (it_q.func)
          djs_pkg::FUNC_OPEN: begin
            if (cnt != '0) begin
              if (open_q || inf_q >= FB'(CONTEXTS - 1) ||
                  (c_rd.owner == nl && c_rd.left != '0)) begin
                res_d.status = djs_pkg::ST_FULL;
              end else begin
                lc_d = nl;
                c_we = 1'b1; c_wa = nl[SB-1:0];
                c_wd = '{owner: nl, next_item: '0, left: cnt, total: cnt,
                         blockers: '0, wcnt: '0};
                open_d = 1'b1; oslot_d = nl[SB-1:0]; inf_d = inf_q + 1'b1;
                res_d.out_label = 32'(nl);
              end
            end
          end
          djs_pkg::FUNC_ADD: begin
            if (!open_q) res_d.status = djs_pkg::ST_NO_OPEN;
            else if (!live || il[SB-1:0] == oslot_q) res_d.status = djs_pkg::ST_NO_JOB;
            else if (c_rd.wcnt >= WCB'(MAX_DEPENDANTS)) begin
              res_d.status = djs_pkg::ST_DEP_FULL;
            end else begin
              c_we = 1'b1; c_wa = il[SB-1:0];
              c_wd.wcnt = c_rd.wcnt + 1'b1;
              w_we = 1'b1;
              w_wa = WAB'(il[SB-1:0]) * WAB'(MAX_DEPENDANTS) + WAB'(c_rd.wcnt);
              rv_d = 1'b0; state_d = S_RD2;
            end
          end
          djs_pkg::FUNC_COMMIT: begin
            if (!open_q) res_d.status = djs_pkg::ST_NO_OPEN;
            else begin
              end_d = c_rd.owner; open_d = 1'b0;
              if (sod_q && c_rd.blockers == '0) begin
                if (c_rd.total == COUNT_BITS'(1)) res_d.wake_one = 1'b1;
                else res_d.wake_all = 1'b1;
              end
            end
          end
          djs_pkg::FUNC_DONE: begin
            if (!live || (open_q && il[SB-1:0] == oslot_q)) begin
              res_d.status = djs_pkg::ST_NO_JOB;
            end else begin
              c_we = 1'b1; c_wa = il[SB-1:0];
              c_wd.left = c_rd.left - 1'b1;
              if (c_rd.left == COUNT_BITS'(1)) begin
                c_wd.wcnt = '0; c_wd.blockers = '0;
                if (inf_q != '0) inf_d = inf_q - 1'b1;
                res_d.wake_waiters = 1'b1;
                fs_d = il[SB-1:0]; wk_d = '0;
                wn_d = (c_rd.wcnt > WCB'(MAX_DEPENDANTS)) ? WCB'(MAX_DEPENDANTS)
                                                          : c_rd.wcnt;
                rv_d = 1'b0; state_d = S_WRD;
              end
            end
          end
          djs_pkg::FUNC_QUERY: res_d.finished = !live;
          default: res_d = '0;
        endcase
      end
      S_RD2: begin
        c_ra = oslot_q; state_d = S_EXEC2;
      end
      S_EXEC2: begin
        w_we = 1'b0;
        c_we = 1'b1; c_wa = oslot_q; c_wd.blockers = c_rd.blockers + 1'b1;
        rv_d = 1'b1; state_d = S_IDLE;
      end
      S_FRD: begin
        if (fi_q == fd_q) begin
          res_d.status = djs_pkg::ST_NO_JOB; rv_d = 1'b1; state_d = S_IDLE;
        end else begin
          fl_d = head_q ? start_q + 1'b1 : end_q - LABEL_BITS'(fd_q) + 1'b1
                 + LABEL_BITS'(fi_q);
          c_ra = fl_d[SB-1:0]; state_d = S_FEX;
        end
      end
      S_FEX: begin
        fi_d = fi_q + 1'b1; state_d = S_FRD;
        if (!(c_rd.owner == fl_q && c_rd.left != '0)) begin
          if (head_q) start_d = fl_q;
        end else if (c_rd.blockers != '0) begin
          head_d = 1'b0;
        end else if (c_rd.next_item < NB'(c_rd.total)) begin
          res_d.out_label = 32'(fl_q);
          res_d.work_index = 16'(c_rd.next_item);
          c_we = 1'b1; c_wa = fl_q[SB-1:0];
          c_wd.next_item = c_rd.next_item + 1'b1;
          rv_d = 1'b1; state_d = S_IDLE;
        end else if (head_q) begin
          start_d = fl_q;
        end
      end
      S_WRD: begin
        if (wk_q == wn_q) begin
          rv_d = 1'b1; state_d = S_IDLE;
        end else begin
          w_ra = WAB'(fs_q) * WAB'(MAX_DEPENDANTS) + WAB'(wk_q);
          state_d = S_WLAB;
        end
      end
      S_WLAB: begin
        wl_d = w_rd; c_ra = w_rd[SB-1:0]; state_d = S_WEX;
      end
      S_WEX: begin
        wk_d = wk_q + 1'b1; state_d = S_WRD;
        if (c_rd.owner == wl_q && c_rd.left != '0 && c_rd.blockers != '0) begin
          c_we = 1'b1; c_wa = wl_q[SB-1:0];
          c_wd.blockers = c_rd.blockers - 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (state_q == S_EXEC && it_q.func == djs_pkg::FUNC_ADD && open_q && live &&
        il[SB-1:0] != oslot_q && c_rd.wcnt < WCB'(MAX_DEPENDANTS)) begin
      w_wd = lc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR; sod_q <= 1'b1; start_q <= '0; end_q <= '0; lc_q <= '0;
      inf_q <= '0; open_q <= 1'b0; oslot_q <= '0; clr_q <= '0; rv_q <= 1'b0;
    end else begin
      state_q <= state_d; start_q <= start_d; end_q <= end_d; lc_q <= lc_d;
      inf_q <= inf_d; open_q <= open_d; oslot_q <= oslot_d; clr_q <= clr_d;
      rv_q <= rv_d;
      if (cfg_valid_i) sod_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    it_q <= it_d; res_q <= res_d; fi_q <= fi_d; fd_q <= fd_d;
    head_q <= head_d; fl_q <= fl_d; wk_q <= wk_d; wn_q <= wn_d; fs_q <= fs_d;
    wl_q <= wl_d;
  end

  assign busy_o = state_q != S_IDLE;
  assign cfg_ready_o = 1'b1;
  assign result_valid_o = rv_q;
  assign result_o = rv_q ? res_q : '0;

  a_busy_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy_o) else $error("result while busy");
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o) else $error("double result");
  a_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inf_q <= FB'(CONTEXTS)) else $error("in-flight overflow");

endmodule

`default_nettype wire

// File: test/testbench.sv
// ---------------------------------------------------------------------------
// testbench: dependency-aware job scheduler regression
// Directed table of scheduler items, then random job lifecycles checked
// against a cycle-free scheduler predictor, with random start idling and
// start_on_dispatch changed between phases while the block is idle.
// ---------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NCTX = 256;
  localparam int NDEP = 8;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start_i = 1'b0;
  logic             busy_o;
  djs_pkg::item_t   item_i = '0;
  logic             result_valid_o;
  djs_pkg::result_t result_o;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic             cfg_data_i = 1'b0;

  dependency_aware_job_scheduler_unit dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .item_i, .result_valid_o, .result_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // predictor state
  logic        wake_on_commit;
  logic [31:0] head_label, tail_label, last_label;
  int unsigned jobs_live;
  logic        job_open;
  logic [7:0]  open_idx;
  logic [31:0] own [NCTX];
  logic [16:0] next_item [NCTX];
  logic [15:0] left_items [NCTX];
  logic [15:0] total_items [NCTX];
  logic [11:0] blockers [NCTX];
  logic [3:0]  nwaiters [NCTX];
  logic [31:0] waiters [NCTX*NDEP];

  djs_pkg::result_t sched_expected [$];
  int               mismatches = 0;

  function automatic logic live(logic [31:0] l);
    return own[l[7:0]] == l && left_items[l[7:0]] != 0;
  endfunction

  function automatic logic is_open(logic [31:0] l);
    return job_open && l[7:0] == open_idx && own[open_idx] == l;
  endfunction

  task automatic sched_reset();
    wake_on_commit = 1'b1;
    head_label = '0; tail_label = '0; last_label = '0;
    jobs_live = 0; job_open = 1'b0; open_idx = '0;
    for (int i = 0; i < NCTX; i++) begin
      own[i] = '0; next_item[i] = '0; left_items[i] = '0;
      total_items[i] = '0; blockers[i] = '0; nwaiters[i] = '0;
    end
  endtask

  function automatic djs_pkg::result_t sched_predict(djs_pkg::item_t it);
    djs_pkg::result_t r;
    logic [31:0] nl, l, w, d;
    logic [7:0] s;
    logic head, got;
    r = '0;
    case (it.func)
      djs_pkg::FUNC_OPEN: if (it.job_count != 0) begin
        nl = last_label + 1;
        s = nl[7:0];
        if (job_open || jobs_live >= NCTX - 1 || live(nl)) begin
          r.status = djs_pkg::ST_FULL;
        end else begin
          last_label = nl; own[s] = nl; next_item[s] = '0;
          left_items[s] = it.job_count; total_items[s] = it.job_count;
          blockers[s] = '0; nwaiters[s] = '0;
          job_open = 1'b1; open_idx = s; jobs_live++;
          r.out_label = nl;
        end
      end
      djs_pkg::FUNC_ADD: begin
        if (!job_open) r.status = djs_pkg::ST_NO_OPEN;
        else if (!live(it.label) || is_open(it.label)) r.status = djs_pkg::ST_NO_JOB;
        else begin
          s = it.label[7:0];
          if (nwaiters[s] >= NDEP) r.status = djs_pkg::ST_DEP_FULL;
          else begin
            waiters[s*NDEP + nwaiters[s]] = own[open_idx];
            nwaiters[s]++;
            blockers[open_idx]++;
          end
        end
      end
      djs_pkg::FUNC_COMMIT: begin
        if (!job_open) r.status = djs_pkg::ST_NO_OPEN;
        else begin
          tail_label = own[open_idx];
          job_open = 1'b0;
          if (wake_on_commit && blockers[open_idx] == 0) begin
            if (total_items[open_idx] == 1) r.wake_one = 1'b1;
            else r.wake_all = 1'b1;
          end
        end
      end
      djs_pkg::FUNC_FETCH: begin
        d = tail_label - head_label;
        head = 1'b1; got = 1'b0;
        if (d > NCTX) begin
          head_label = tail_label - NCTX;
          d = NCTX;
        end
        for (int unsigned i = 0; i < d && !got; i++) begin
          l = head ? head_label + 1 : tail_label - d + 1 + i;
          s = l[7:0];
          if (!live(l)) begin
            if (head) head_label = l;
          end else if (blockers[s] > 0) begin
            head = 1'b0;
          end else if (next_item[s] < {1'b0, total_items[s]}) begin
            r.out_label = l; r.work_index = next_item[s][15:0];
            next_item[s]++; got = 1'b1;
          end else if (head) begin
            head_label = l;
          end
        end
        if (!got) r.status = djs_pkg::ST_NO_JOB;
      end
      djs_pkg::FUNC_DONE: begin
        if (!live(it.label) || is_open(it.label)) r.status = djs_pkg::ST_NO_JOB;
        else begin
          s = it.label[7:0];
          left_items[s]--;
          if (left_items[s] == 0) begin
            for (int k = 0; k < nwaiters[s] && k < NDEP; k++) begin
              w = waiters[s*NDEP + k];
              if (live(w) && blockers[w[7:0]] > 0) blockers[w[7:0]]--;
            end
            nwaiters[s] = '0; blockers[s] = '0;
            if (jobs_live > 0) jobs_live--;
            r.wake_waiters = 1'b1;
          end
        end
      end
      djs_pkg::FUNC_QUERY: r.finished = !live(it.label);
      default: ;
    endcase
    return r;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (sched_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", result_o);
      end else begin
        djs_pkg::result_t e;
        e = sched_expected.pop_front();
        if (e.status !== result_o.status || e.out_label !== result_o.out_label ||
            e.work_index !== result_o.work_index || e.finished !== result_o.finished ||
            e.wake_one !== result_o.wake_one || e.wake_all !== result_o.wake_all ||
            e.wake_waiters !== result_o.wake_waiters) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch exp %p got %p", e, result_o);
        end
      end
    end
  end

  logic quiet_phase = 1'b0;

  task automatic issue(djs_pkg::item_t it, logic has_golden, djs_pkg::result_t golden);
    djs_pkg::result_t p;
    if (!quiet_phase && $urandom_range(0, 5) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    start_i <= 1'b1;
    item_i <= it;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    p = sched_predict(it);
    if (has_golden && p !== golden) begin
      mismatches++;
      if (mismatches <= 10) $display("table row exp %p predictor %p", golden, p);
    end
    sched_expected.push_back(p);
  endtask

  task automatic drain();
    start_i <= 1'b0;
    while (sched_expected.size() != 0) @(posedge clk_i);
    repeat (800) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic v);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    wake_on_commit = v;
  endtask

  function automatic djs_pkg::item_t mk(djs_pkg::func_e f, logic [15:0] c,
                                        logic [31:0] l);
    djs_pkg::item_t it;
    it.func = f; it.job_count = c; it.label = l;
    return it;
  endfunction

  function automatic djs_pkg::result_t rs(djs_pkg::status_e st, logic [31:0] ol,
                                          logic w1, logic wa);
    djs_pkg::result_t r;
    r = '0; r.status = st; r.out_label = ol; r.wake_one = w1; r.wake_all = wa;
    return r;
  endfunction

  typedef struct {
    djs_pkg::item_t   it;
    logic             has_golden;
    djs_pkg::result_t golden;
  } row_t;

  function automatic logic [31:0] pick_label();
    if ($urandom_range(0, 9) == 0) return $urandom();
    if (last_label == 0) return $urandom_range(0, 3);
    return last_label - $urandom_range(0, 12);
  endfunction

  initial begin
    row_t rows [$];
    djs_pkg::item_t it;
    djs_pkg::result_t none;
    none = '0;
    sched_reset();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    rows = '{
      '{mk(djs_pkg::FUNC_FETCH, 16'd0, 32'd0), 1'b1, rs(djs_pkg::ST_NO_JOB, 0, 0, 0)},
      '{mk(djs_pkg::FUNC_ADD, 16'd0, 32'd1), 1'b1, rs(djs_pkg::ST_NO_OPEN, 0, 0, 0)},
      '{mk(djs_pkg::FUNC_COMMIT, 16'd0, 32'd0), 1'b1, rs(djs_pkg::ST_NO_OPEN, 0, 0, 0)},
      '{mk(djs_pkg::FUNC_DONE, 16'd0, 32'hFFFF_FFFF), 1'b1,
        rs(djs_pkg::ST_NO_JOB, 0, 0, 0)},
      '{mk(djs_pkg::FUNC_OPEN, 16'd0, 32'd0), 1'b1, rs(djs_pkg::ST_OK, 0, 0, 0)},
      '{mk(djs_pkg::FUNC_OPEN, 16'd1, 32'd0), 1'b1, rs(djs_pkg::ST_OK, 1, 0, 0)},
      '{mk(djs_pkg::FUNC_OPEN, 16'd3, 32'd0), 1'b1, rs(djs_pkg::ST_FULL, 0, 0, 0)},
      '{mk(djs_pkg::FUNC_ADD, 16'd0, 32'd1), 1'b1, rs(djs_pkg::ST_NO_JOB, 0, 0, 0)},
      '{mk(djs_pkg::FUNC_DONE, 16'd0, 32'd1), 1'b1, rs(djs_pkg::ST_NO_JOB, 0, 0, 0)},
      '{mk(djs_pkg::FUNC_COMMIT, 16'd0, 32'd0), 1'b1, rs(djs_pkg::ST_OK, 0, 1, 0)},
      '{mk(djs_pkg::FUNC_OPEN, 16'hFFFF, 32'd0), 1'b1, rs(djs_pkg::ST_OK, 2, 0, 0)},
      '{mk(djs_pkg::FUNC_ADD, 16'd0, 32'd1), 1'b0, none},
      '{mk(djs_pkg::FUNC_COMMIT, 16'd0, 32'd0), 1'b1, rs(djs_pkg::ST_OK, 0, 0, 0)},
      '{mk(djs_pkg::FUNC_QUERY, 16'd0, 32'd2), 1'b0, none},
      '{mk(djs_pkg::FUNC_FETCH, 16'd0, 32'd0), 1'b0, none},
      '{mk(djs_pkg::FUNC_FETCH, 16'd0, 32'd0), 1'b0, none},
      '{mk(djs_pkg::FUNC_DONE, 16'd0, 32'd1), 1'b0, none},
      '{mk(djs_pkg::FUNC_QUERY, 16'd0, 32'd1), 1'b0, none},
      '{mk(djs_pkg::FUNC_FETCH, 16'd0, 32'd0), 1'b0, none},
      '{mk(djs_pkg::FUNC_OPEN, 16'd2, 32'd0), 1'b0, none},
      '{mk(djs_pkg::FUNC_COMMIT, 16'd0, 32'd0), 1'b0, none},
      '{mk(djs_pkg::func_e'(3'd6), 16'hFFFF, 32'hFFFF_FFFF), 1'b1, none},
      '{mk(djs_pkg::func_e'(3'd7), 16'd0, 32'd0), 1'b1, none}
    };
    foreach (rows[i]) issue(rows[i].it, rows[i].has_golden, rows[i].golden);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      write_cfg(ph[0]);
      if (ph == 3) quiet_phase = 1'b1;
      for (int n = 0; n < 250; n++) begin
        int sel;
        sel = $urandom_range(0, 99);
        it = '0;
        it.label = pick_label();
        it.job_count = $urandom_range(0, 7) == 0 ? 16'($urandom())
                                                 : 16'($urandom_range(1, 4));
        if (sel < 15) it.func = djs_pkg::FUNC_OPEN;
        else if (sel < 27) it.func = djs_pkg::FUNC_ADD;
        else if (sel < 40) it.func = djs_pkg::FUNC_COMMIT;
        else if (sel < 65) it.func = djs_pkg::FUNC_FETCH;
        else if (sel < 88) it.func = djs_pkg::FUNC_DONE;
        else if (sel < 97) it.func = djs_pkg::FUNC_QUERY;
        else it.func = djs_pkg::func_e'($urandom_range(6, 7));
        issue(it, 1'b0, none);
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

`default_nettype wire
